// ===== hw/rtl/lag_pkg.sv =====
// Shared types, constants and helper functions for the life automaton generation block.
package lag_pkg;

    // Default grid size.
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Field widths fixed by the item format.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int ROW_IN_W  = 6;
    localparam int COL_IN_W  = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Reset value of both area registers.
    localparam logic [CFG_W-1:0] AREA_RESET = 7'd64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // Operation carried in s_tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_PRIME,
        ST_SWEEP,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input transaction and start its row read
        logic clr_wr;     // write a zero row at the counter (clearing pass)
        logic row_ready;  // read data for a cell access is available
        logic prime;      // load the first row into the window
        logic sweep;      // compute and write back the row at the counter
        logic ctr_clr;
        logic ctr_inc;
        logic out_load;   // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ctr_last;
    } sts_t;

    // Next state of one cell from its three neighbors above, the two beside
    // it, the three below and its own value.
    function automatic logic life_next(logic [2:0] up3, logic [1:0] side2,
                                       logic [2:0] dn3, logic self);
        logic [7:0] nb;
        logic [3:0] cnt;
        nb  = {up3, side2, dn3};
        cnt = 4'd0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + {3'b000, nb[i]};
        end
        return (cnt == 4'd3) || (self && (cnt == 4'd2));
    endfunction

endpackage

// ===== hw/rtl/life_automaton_generation.sv =====
// Top level of the life automaton generation block (rule B3/S23 on a bounded grid).
//
//  channel   direction  signals                         contents
//  s_        in         s_tvalid s_tready s_tdata       row_index, col_index, cell_in
//                       s_tuser                         mode
//  m_        out        m_tvalid m_tready m_tdata       cell_out
//                       m_tuser                         addr_error
//  cfg_      in         cfg_valid cfg_ready             cfg_index, cfg_data
//
//  One item is worked on at a time. A cell write or read reads its grid row and loads its
//  result into the output register from the finish state (for a write, a read-modify-write
//  of one grid row); a generation step primes the window, then sweeps one grid row per cycle.
//  The next item is taken in the cycle after the load; a result still waiting on the m_
//  side holds back the load of the following result until it is taken.
//  After reset a clearing pass zeros all MAX_ROWS rows, one per cycle, with s_tready low.
module life_automaton_generation #(
    parameter int MAX_ROWS = lag_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lag_pkg::MAX_COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Bits from 0: row_index[5:0], col_index[11:6], cell_in[12], zero [15:13].
    input  logic [lag_pkg::S_TDATA_W-1:0]   s_tdata,
    // Bits from 0: mode[1:0].
    input  logic [lag_pkg::MODE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Bits from 0: cell_out[0], zero [7:1].
    output logic [lag_pkg::M_TDATA_W-1:0]   m_tdata,
    // Bits from 0: addr_error[0].
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lag_pkg::CFG_W-1:0]       cfg_data
);

    lag_pkg::cmd_t cmd;
    lag_pkg::sts_t sts;

    // Configuration transactions are always taken.
    assign cfg_ready = 1'b1;

    lag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lag_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hw/rtl/lag_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lag_ram #(
    parameter int WIDTH = lag_pkg::MAX_COLS_DEF,
    parameter int DEPTH = lag_pkg::MAX_ROWS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lag_dp.sv =====
// Datapath: area registers, row window, neighbor logic, grid memory and result registers.
module lag_dp #(
    parameter int MAX_ROWS = lag_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lag_pkg::MAX_COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lag_pkg::cmd_t                   cmd,
    output lag_pkg::sts_t                   sts,
    input  logic [lag_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lag_pkg::MODE_W-1:0]      s_tuser,
    input  logic                            cfg_we,
    input  logic [lag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lag_pkg::CFG_W-1:0]       cfg_data,
    output logic [lag_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser
);

    localparam int RA_W = $clog2(MAX_ROWS);
    localparam int CA_W = $clog2(MAX_COLS);
    localparam int CW   = (RA_W + 1 > lag_pkg::CFG_W) ? RA_W + 1 : lag_pkg::CFG_W;
    localparam int KW   = (CA_W + 1 > lag_pkg::CFG_W) ? CA_W + 1 : lag_pkg::CFG_W;

    // Area registers and the row counter.
    logic [lag_pkg::CFG_W-1:0] rows_reg, rows_next;
    logic [lag_pkg::CFG_W-1:0] cols_reg, cols_next;
    logic [RA_W-1:0]           ctr_reg, ctr_next;

    // Latched item, result and window.
    lag_pkg::mode_t                lmode_reg;
    logic [lag_pkg::ROW_IN_W-1:0]  lrow_reg;
    logic [lag_pkg::COL_IN_W-1:0]  lcol_reg;
    logic                          lval_reg;
    logic                          lok_reg;
    logic                          res_cell_reg;
    logic                          res_err_reg;
    logic                          m_cell_reg;
    logic                          m_err_reg;
    logic [MAX_COLS-1:0]           up_reg;
    logic [MAX_COLS-1:0]           mid_reg;

    // Input unpacking.
    logic [lag_pkg::ROW_IN_W-1:0] in_row;
    logic [lag_pkg::COL_IN_W-1:0] in_col;
    logic                         in_val;
    lag_pkg::mode_t               in_mode;
    logic                         in_ok;

    assign in_row  = s_tdata[lag_pkg::ROW_IN_W-1:0];
    assign in_col  = s_tdata[lag_pkg::ROW_IN_W +: lag_pkg::COL_IN_W];
    assign in_val  = s_tdata[lag_pkg::ROW_IN_W + lag_pkg::COL_IN_W];
    assign in_mode = lag_pkg::mode_t'(s_tuser);

    // An address is in the area when it is below both the register and the grid size.
    assign in_ok = (CW'(in_row) < CW'(rows_reg)) && (CW'(in_row) < CW'(MAX_ROWS)) &&
                   (KW'(in_col) < KW'(cols_reg)) && (KW'(in_col) < KW'(MAX_COLS));

    // Column mask of the area in use.
    logic [MAX_COLS-1:0] col_mask;
    for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
        assign col_mask[j] = KW'(j) < KW'(cols_reg);
    end

    // Memory ports.
    logic                ram_we;
    logic [RA_W-1:0]     ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [RA_W-1:0]     ram_raddr;
    logic [MAX_COLS-1:0] ram_rdata;

    lag_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Row window: the row above, the current row and the row below.
    logic [CW-1:0]       ctr_ext;
    logic [CW-1:0]       ctr_p1;
    logic                mid_in_area;
    logic                down_ok;
    logic [MAX_COLS-1:0] down_row;
    logic [MAX_COLS-1:0] mid_m;
    logic [RA_W:0]       ahead;
    logic                ahead_ok;

    assign ctr_ext     = CW'(ctr_reg);
    assign ctr_p1      = ctr_ext + CW'(1);
    assign mid_in_area = ctr_ext < CW'(rows_reg);
    assign down_ok     = (ctr_p1 < CW'(rows_reg)) && (ctr_p1 < CW'(MAX_ROWS));
    assign down_row    = down_ok ? (ram_rdata & col_mask) : '0;
    assign mid_m       = mid_reg & col_mask;
    assign ahead       = {1'b0, ctr_reg} + (RA_W + 1)'(2);
    assign ahead_ok    = ahead < (RA_W + 1)'(MAX_ROWS);

    // Next generation of the current row; columns outside the area keep their value.
    logic [MAX_COLS+1:0] up_pad, mid_pad, dn_pad;
    logic [MAX_COLS-1:0] new_row;

    assign up_pad  = {1'b0, up_reg, 1'b0};
    assign mid_pad = {1'b0, mid_m, 1'b0};
    assign dn_pad  = {1'b0, down_row, 1'b0};

    for (genvar j = 0; j < MAX_COLS; j++) begin : g_life
        logic nxt;
        assign nxt = lag_pkg::life_next(up_pad[j +: 3],
                                        {mid_pad[j + 2], mid_pad[j]},
                                        dn_pad[j +: 3], mid_pad[j + 1]);
        assign new_row[j] = col_mask[j] ? nxt : mid_reg[j];
    end

    // Single cell replaced in the row just read.
    logic [CA_W-1:0]     col_sel;
    logic [MAX_COLS-1:0] rmw_row;

    assign col_sel = CA_W'(lcol_reg);

    always_comb begin
        rmw_row          = ram_rdata;
        rmw_row[col_sel] = lval_reg;
    end

    // Read address selection.
    always_comb begin
        ram_raddr = '0;
        if (cmd.accept && (in_mode != lag_pkg::MODE_STEP)) begin
            ram_raddr = RA_W'(in_row);
        end else if (cmd.prime) begin
            ram_raddr = RA_W'(1);
        end else if (cmd.sweep && ahead_ok) begin
            ram_raddr = ahead[RA_W-1:0];
        end
    end

    // Write port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ctr_reg;
        ram_wdata = '0;
        if (cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (cmd.row_ready) begin
            ram_we    = (lmode_reg == lag_pkg::MODE_WRITE) && lok_reg;
            ram_waddr = RA_W'(lrow_reg);
            ram_wdata = rmw_row;
        end else if (cmd.sweep) begin
            ram_we    = mid_in_area;
            ram_wdata = new_row;
        end
    end

    // Configuration writes and row counter.
    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we && (cfg_index == lag_pkg::REG_ROWS)) begin
            rows_next = cfg_data;
        end
        if (cfg_we && (cfg_index == lag_pkg::REG_COLS)) begin
            cols_next = cfg_data;
        end
        ctr_next = ctr_reg;
        if (cmd.ctr_clr) begin
            ctr_next = '0;
        end else if (cmd.ctr_inc) begin
            ctr_next = ctr_reg + RA_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= lag_pkg::AREA_RESET;
            cols_reg <= lag_pkg::AREA_RESET;
            ctr_reg  <= '0;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            ctr_reg  <= ctr_next;
        end
    end

    assign sts.ctr_last = ctr_reg == RA_W'(MAX_ROWS - 1);

    // Item, window and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lmode_reg    <= in_mode;
            lrow_reg     <= in_row;
            lcol_reg     <= in_col;
            lval_reg     <= in_val;
            lok_reg      <= in_ok;
            res_cell_reg <= 1'b0;
            res_err_reg  <= ((in_mode == lag_pkg::MODE_WRITE) ||
                             (in_mode == lag_pkg::MODE_READ)) && !in_ok;
        end
        if (cmd.row_ready && (lmode_reg == lag_pkg::MODE_READ)) begin
            res_cell_reg <= lok_reg && ram_rdata[col_sel];
        end
        if (cmd.prime) begin
            up_reg  <= '0;
            mid_reg <= ram_rdata;
        end else if (cmd.sweep) begin
            up_reg  <= mid_m;
            mid_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            m_cell_reg <= res_cell_reg;
            m_err_reg  <= res_err_reg;
        end
    end

    assign m_tdata = {{(lag_pkg::M_TDATA_W - 1){1'b0}}, m_cell_reg};
    assign m_tuser = m_err_reg;

endmodule

// ===== hw/rtl/lag_ctrl.sv =====
// Controller state machine: clearing pass, item sequencing, generation sweep and output handshake.
module lag_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lag_pkg::MODE_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output lag_pkg::cmd_t               cmd,
    input  lag_pkg::sts_t               sts
);

    lag_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // State register and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lag_pkg::ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            lag_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.ctr_last) begin
                    cmd.ctr_clr = 1'b1;
                    state_next  = lag_pkg::ST_IDLE;
                end else begin
                    cmd.ctr_inc = 1'b1;
                end
            end
            lag_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (lag_pkg::mode_t'(s_tuser))
                        lag_pkg::MODE_WRITE: state_next = lag_pkg::ST_ROW;
                        lag_pkg::MODE_READ:  state_next = lag_pkg::ST_ROW;
                        lag_pkg::MODE_STEP:  state_next = lag_pkg::ST_PRIME;
                        default:             state_next = lag_pkg::ST_FIN;
                    endcase
                end
            end
            lag_pkg::ST_ROW: begin
                cmd.row_ready = 1'b1;
                state_next    = lag_pkg::ST_FIN;
            end
            lag_pkg::ST_PRIME: begin
                cmd.prime   = 1'b1;
                cmd.ctr_clr = 1'b1;
                state_next  = lag_pkg::ST_SWEEP;
            end
            lag_pkg::ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.ctr_last) begin
                    cmd.ctr_clr = 1'b1;
                    state_next  = lag_pkg::ST_FIN;
                end else begin
                    cmd.ctr_inc = 1'b1;
                end
            end
            lag_pkg::ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = lag_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lag_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Only one item is in flight: an accepted transaction leaves the idle state.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != lag_pkg::ST_IDLE))
        else $error("second item taken while one is in flight");

    // Priming is always followed by the row sweep.
    a_prime_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lag_pkg::ST_PRIME) |=> (state_reg == lag_pkg::ST_SWEEP))
        else $error("sweep did not follow priming");

    // The sweep ends exactly after the last row.
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lag_pkg::ST_SWEEP && sts.ctr_last) |=> (state_reg == lag_pkg::ST_FIN))
        else $error("sweep did not finish after the last row");

    // A loaded result shows up as a valid output transaction.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result loaded but output not valid");

    // Results are never produced during the clearing pass.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lag_pkg::ST_CLEAR) |-> !cmd.out_load && !cmd.sweep)
        else $error("activity during clearing pass");

endmodule

// ===== tb/life_automaton_generation_tb.sv =====
// Self-checking testbench for the B3/S23 life automaton block, with its own grid predictor.
module life_automaton_generation_tb;

    localparam int GRID_ROWS      = lag_pkg::MAX_ROWS_DEF;
    localparam int GRID_COLS      = lag_pkg::MAX_COLS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = GRID_ROWS + 20;

    // Register indexes that the block does not decode.
    localparam logic [lag_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [lag_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        lag_pkg::mode_t mode;
        logic [5:0]     row;
        logic [5:0]     col;
        logic           cell_in;
    } cell_op_t;

    typedef struct packed {
        logic cell_out;
        logic addr_error;
    } cell_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [lag_pkg::S_TDATA_W-1:0] s_tdata;
    logic [lag_pkg::MODE_W-1:0]    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [lag_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lag_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lag_pkg::CFG_W-1:0]     cfg_data;

    // Predictor state: one 64-bit word per grid row, bit index is the column.
    logic [GRID_COLS-1:0]      life_grid [GRID_ROWS];
    logic [lag_pkg::CFG_W-1:0] rows_cfg;
    logic [lag_pkg::CFG_W-1:0] cols_cfg;

    cell_op_t     op_queue [$];
    cell_result_t expected_cells [$];

    int  ops_pushed;
    int  results_seen;
    int  error_count;
    int  stall_cycles;
    int  snd_gap_max;
    int  rcv_gap_max;
    logic s_took;
    logic m_took;
    logic cfg_took;

    life_automaton_generation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The area in use is limited to the grid size.
    function automatic int area_rows();
        return (rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
    endfunction

    function automatic int area_cols();
        return (cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
    endfunction

    // One Conway generation over the area in use; cells outside it keep their value
    // and count as dead.
    function automatic void advance_generation();
        logic [GRID_COLS-1:0] nxt [GRID_ROWS];
        int nr, nc, cnt, rr, cc;
        nr = area_rows();
        nc = area_cols();
        if (nr == 0 || nc == 0) return;
        nxt = life_grid;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                cnt = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                            cnt += int'(life_grid[rr][cc]);
                    end
                end
                nxt[r][c] = (cnt == 3) || (life_grid[r][c] && cnt == 2);
            end
        end
        life_grid = nxt;
    endfunction

    // Applies one accepted operation to the predicted grid and returns its result.
    function automatic cell_result_t predict_cell_op(cell_op_t op);
        cell_result_t res;
        res = '0;
        case (op.mode)
            lag_pkg::MODE_WRITE, lag_pkg::MODE_READ: begin
                if (op.row >= area_rows() || op.col >= area_cols())
                    res.addr_error = 1'b1;
                else if (op.mode == lag_pkg::MODE_WRITE)
                    life_grid[op.row][op.col] = op.cell_in;
                else
                    res.cell_out = life_grid[op.row][op.col];
            end
            lag_pkg::MODE_STEP: advance_generation();
            default: ;
        endcase
        return res;
    endfunction

    function automatic void flag_mismatch(string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", msg);
    endfunction

    // Monitor: predicts on every accepted input transaction, checks every accepted
    // result transaction, tracks register writes and runs the watchdog.
    always @(posedge aclk) begin
        cell_op_t     op;
        cell_result_t want;
        if (!aresetn) begin
            s_took       <= 1'b0;
            m_took       <= 1'b0;
            cfg_took     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            s_took   <= s_tvalid && s_tready;
            m_took   <= m_tvalid && m_tready;
            cfg_took <= cfg_valid && cfg_ready;
            if (s_tvalid && s_tready) begin
                op.mode        = lag_pkg::mode_t'(s_tuser);
                op.row         = s_tdata[5:0];
                op.col         = s_tdata[11:6];
                op.cell_in     = s_tdata[12];
                want           = predict_cell_op(op);
                expected_cells = {expected_cells, want};
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lag_pkg::REG_ROWS) rows_cfg <= cfg_data;
                else if (cfg_index == lag_pkg::REG_COLS) cols_cfg <= cfg_data;
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_cells.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    want = expected_cells.pop_front();
                    if (m_tdata[0] !== want.cell_out || m_tuser !== want.addr_error)
                        flag_mismatch($sformatf(
                            "result %0d: cell_out exp %0b got %0b, addr_error exp %0b got %0b",
                            results_seen, want.cell_out, m_tdata[0],
                            want.addr_error, m_tuser));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("life_automaton_generation_tb: done, errors");
                $finish;
            end
        end
    end

    // Driver: presents queued operations with a random gap after each one and
    // puts noise on the data lines while idle.
    always @(negedge aclk) begin
        cell_op_t cur;
        bit       presenting;
        int       snd_wait;
        if (aresetn) begin
            if (s_took) presenting = 1'b0;
            if (!presenting) begin
                if (snd_wait > 0) begin
                    snd_wait--;
                end else if (op_queue.size() > 0) begin
                    cur        = op_queue.pop_front();
                    presenting = 1'b1;
                    snd_wait   = $urandom_range(0, snd_gap_max);
                end
            end
        end
        s_tvalid <= presenting;
        s_tdata  <= presenting ? {3'b000, cur.cell_in, cur.col, cur.row}
                               : lag_pkg::S_TDATA_W'($urandom);
        s_tuser  <= presenting ? cur.mode : lag_pkg::MODE_W'($urandom);
    end

    // Result side: stalls a random number of cycles after each taken transaction.
    always @(negedge aclk) begin
        int rcv_wait;
        if (m_took) rcv_wait = $urandom_range(0, rcv_gap_max);
        if (rcv_wait > 0) begin
            m_tready <= 1'b0;
            rcv_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Appends one operation to the sender's queue.
    task automatic enqueue_op(cell_op_t op);
        op_queue = {op_queue, op};
        ops_pushed++;
    endtask

    task automatic push_op(lag_pkg::mode_t mode, int row, int col, bit cell_in);
        cell_op_t op;
        op.mode    = mode;
        op.row     = 6'(row);
        op.col     = 6'(col);
        op.cell_in = cell_in;
        enqueue_op(op);
    endtask

    // Random operation, mostly inside the area in use and often near its edges,
    // so that generations see dense neighborhoods and the border rule.
    function automatic cell_op_t random_op();
        cell_op_t op;
        int pick, nr, nc;
        nr   = area_rows();
        nc   = area_cols();
        pick = $urandom_range(0, 99);
        if (pick < 45)      op.mode = lag_pkg::MODE_WRITE;
        else if (pick < 60) op.mode = lag_pkg::MODE_STEP;
        else if (pick < 95) op.mode = lag_pkg::MODE_READ;
        else                op.mode = lag_pkg::MODE_NONE;
        if ($urandom_range(0, 99) < 85 && nr > 0 && nc > 0) begin
            if (nr > 12 && $urandom_range(0, 1))
                op.row = $urandom_range(0, 1) ? 6'($urandom_range(0, 5))
                                              : 6'($urandom_range(nr - 6, nr - 1));
            else
                op.row = 6'($urandom_range(0, nr - 1));
            if (nc > 12 && $urandom_range(0, 1))
                op.col = $urandom_range(0, 1) ? 6'($urandom_range(0, 5))
                                              : 6'($urandom_range(nc - 6, nc - 1));
            else
                op.col = 6'($urandom_range(0, nc - 1));
        end else begin
            op.row = 6'($urandom);
            op.col = 6'($urandom);
        end
        op.cell_in = ($urandom_range(0, 99) < 65);
        return op;
    endfunction

    // The sender holds off here until every expected result has been taken.
    task automatic wait_results();
        while (results_seen != ops_pushed) @(negedge aclk);
    endtask

    task automatic write_reg(logic [lag_pkg::CFG_IDX_W-1:0] idx,
                             logic [lag_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(negedge aclk);
            if (cfg_took) break;
        end
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed corner cases, then random phases under varied areas.
    initial begin
        int phase_rows [10];
        int phase_cols [10];
        int n_ops;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        ops_pushed   = 0;
        results_seen = 0;
        error_count  = 0;
        snd_gap_max  = 9;
        rcv_gap_max  = 9;
        rows_cfg     = lag_pkg::AREA_RESET;
        cols_cfg     = lag_pkg::AREA_RESET;
        for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Cleared grid, far corners, a corner birth, a blinker and the unused mode.
        push_op(lag_pkg::MODE_READ, 0, 0, 1'b0);
        push_op(lag_pkg::MODE_READ, 63, 63, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 0, 0, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 63, 63, 1'b1);
        push_op(lag_pkg::MODE_READ, 0, 0, 1'b0);
        push_op(lag_pkg::MODE_READ, 63, 63, 1'b0);
        push_op(lag_pkg::MODE_WRITE, 0, 1, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 1, 0, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 20, 30, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 20, 31, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 20, 32, 1'b1);
        push_op(lag_pkg::MODE_STEP, 63, 63, 1'b1);
        push_op(lag_pkg::MODE_READ, 1, 1, 1'b0);
        push_op(lag_pkg::MODE_READ, 19, 31, 1'b0);
        push_op(lag_pkg::MODE_READ, 63, 63, 1'b0);
        push_op(lag_pkg::MODE_NONE, 63, 63, 1'b1);
        push_op(lag_pkg::MODE_WRITE, 0, 0, 1'b0);
        push_op(lag_pkg::MODE_READ, 0, 0, 1'b0);
        wait_results();

        // Small area: out-of-area accesses are flagged, outside cells keep their value.
        write_reg(lag_pkg::REG_ROWS, 7'd3);
        write_reg(lag_pkg::REG_COLS, 7'd3);
        push_op(lag_pkg::MODE_READ, 3, 0, 1'b0);
        push_op(lag_pkg::MODE_WRITE, 0, 3, 1'b1);
        push_op(lag_pkg::MODE_READ, 2, 2, 1'b0);
        push_op(lag_pkg::MODE_STEP, 0, 0, 1'b0);
        wait_results();

        // Empty area: cell accesses are flagged and a generation changes nothing.
        write_reg(lag_pkg::REG_ROWS, 7'd0);
        push_op(lag_pkg::MODE_WRITE, 0, 0, 1'b1);
        push_op(lag_pkg::MODE_STEP, 0, 0, 1'b0);
        wait_results();

        // Undecoded register indexes are ignored.
        write_reg(REG_SPARE_A, 7'($urandom));
        write_reg(REG_SPARE_B, 7'($urandom));

        phase_rows = '{64, 1, 64, 3, 127, 0, 8, 0, 0, 0};
        phase_cols = '{64, 64, 1, 3, 100, 12, 13, 0, 0, 0};
        for (int ph = 7; ph < 10; ph++) begin
            phase_rows[ph] = $urandom_range(2, 20);
            phase_cols[ph] = $urandom_range(2, 20);
        end
        phase_cols[9] = 65;

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(lag_pkg::REG_ROWS, 7'(phase_rows[ph]));
            write_reg(lag_pkg::REG_COLS, 7'(phase_cols[ph]));
            snd_gap_max = (ph % 3 == 1) ? 0 : 9;
            rcv_gap_max = (ph % 4 == 2) ? 0 : 9;
            n_ops = (phase_rows[ph] == 0) ? 15 : 54;
            for (int i = 0; i < n_ops; i++) begin
                enqueue_op(random_op());
            end
            wait_results();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_cells.size() == 0) begin
            $display("life_automaton_generation_tb: done, clean");
        end else begin
            $display("life_automaton_generation_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lag_pkg.sv
hw/rtl/lag_ram.sv
hw/rtl/lag_dp.sv
hw/rtl/lag_ctrl.sv
hw/rtl/life_automaton_generation.sv
tb/life_automaton_generation_tb.sv
